[sv/sfcd_pkg.sv]
// Shared types and constants for the sensor frame CRC decoder.
// No dependencies.
`timescale 1ns / 1ps

package sfcd_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int CRC_LEN     = FRAME_BYTES - 2;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [15:0]      CRC_INIT = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY = 16'hA001;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CRC_END  = POS_W'(CRC_LEN);

    localparam logic [7:0] SIGN_BIT = 8'h80;
    localparam logic [7:0] MAG_MASK = 8'h7F;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic               last;
        logic               ok;
        logic signed [15:0] temp;
        logic [15:0]        hum;
    } t_frame_res;

endpackage

[sv/sensor_frame_crc_decode.sv]
// Sensor reply frame decoder: top level with input and result registers.
// Depends on sfcd_pkg and sfcd_frame.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel  i_in_valid / o_in_ready carries one frame byte per item
//   (i_rx_byte) and i_frame_start, which marks byte 0 and restarts the frame.
//   Result channel o_out_valid / i_out_ready carries one item after every
//   eighth byte: o_frame_ok and the held humidity and temperature in tenths.
//   Readings are updated only when the received CRC-16 (bytes 6 low, 7 high)
//   matches the one computed over bytes 0 to 5.
//   Throughput: one byte per cycle unless a last byte waits on a pending
//   result; the byte-wide CRC update is combinational between the input
//   register and the result register, which a last byte passes in turn.
//   Reset (synchronous, active low) clears position, CRC and held readings
//   and drops any item in flight.
//   Stall: while a result waits, bytes that give no result keep flowing;
//   a last byte waits in the input register, and o_in_ready drops only
//   when that register is held.

module sensor_frame_crc_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_frame_ok,
    output logic signed [15:0] o_temperature_tenths,
    output logic [15:0]        o_humidity_tenths
);
    import sfcd_pkg::*;

    logic               r_in_valid;
    t_byte              r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    logic               r_ok;
    logic signed [15:0] r_temp;
    logic [15:0]        r_hum;

    t_frame_res res;
    logic       out_free, s1_fire, in_fire;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_in_valid && (!res.last || out_free);
    assign o_in_ready = !r_in_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    sfcd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_data  (r_in_byte),
        .i_start (r_in_start),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (s1_fire) begin
                r_in_valid <= 1'b0;
            end
            if (s1_fire && res.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
        end
        if (s1_fire && res.last) begin
            r_ok   <= res.ok;
            r_temp <= res.temp;
            r_hum  <= res.hum;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_frame_ok           = r_ok;
    assign o_temperature_tenths = r_temp;
    assign o_humidity_tenths    = r_hum;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(s1_fire && res.last))
        else $error("pending result overwritten");
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s1_fire) |=> (r_in_valid && $stable(r_in_byte)
                                      && $stable(r_in_start)))
        else $error("stalled input item lost");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("items survive reset");
`endif

endmodule

[sv/sfcd_crc8.sv]
// Byte-wide reflected CRC-16 update, eight bit steps unrolled.
// Depends on sfcd_pkg.
`timescale 1ns / 1ps

module sfcd_crc8 (
    input  logic [15:0]   i_crc,
    input  sfcd_pkg::t_byte i_data,
    output logic [15:0]   o_crc
);
    import sfcd_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

[sv/sfcd_frame.sv]
// Frame state: byte position, running CRC, byte store and held readings.
// Depends on sfcd_pkg and sfcd_crc8.
`timescale 1ns / 1ps

module sfcd_frame (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  sfcd_pkg::t_byte       i_data,
    input  logic                  i_start,
    output sfcd_pkg::t_frame_res  o_res
);
    import sfcd_pkg::*;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [15:0]        r_crc, n_crc;
    t_byte              r_store [FRAME_BYTES];
    logic signed [15:0] r_temp, n_temp;
    logic [15:0]        r_hum, n_hum;

    logic [POS_W-1:0] pos;
    logic [15:0]      crc_base, crc_upd, crc_eff;
    logic [14:0]      mag;
    logic             ok;

    assign pos      = i_start ? '0 : r_pos;
    assign crc_base = i_start ? CRC_INIT : r_crc;

    sfcd_crc8 u_crc (
        .i_crc  (crc_base),
        .i_data (i_data),
        .o_crc  (crc_upd)
    );

    // The current byte is byte 7 whenever the result is formed.
    assign crc_eff = (pos < CRC_END) ? crc_upd : crc_base;
    assign ok      = ({i_data, r_store[6]} == crc_eff);
    assign mag     = {r_store[4][6:0] & MAG_MASK[6:0], r_store[5]};

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_temp = r_temp;
        n_hum  = r_hum;
        if (i_fire) begin
            if (pos == LAST_POS) begin
                n_pos = '0;
                n_crc = CRC_INIT;
                if (ok) begin
                    if ((r_store[4] & SIGN_BIT) != 8'h00) begin
                        n_temp = -$signed({1'b0, mag});
                    end else begin
                        n_temp = $signed({1'b0, mag});
                    end
                    n_hum = {r_store[2], r_store[3]};
                end
            end else begin
                n_pos = pos + POS_W'(1);
                n_crc = crc_eff;
            end
        end
    end

    assign o_res.last = (pos == LAST_POS);
    assign o_res.ok   = ok;
    assign o_res.temp = n_temp;
    assign o_res.hum  = n_hum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= CRC_INIT;
            r_temp <= '0;
            r_hum  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_temp <= n_temp;
            r_hum  <= n_hum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_store[pos] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.last) |=> (r_pos == '0 && r_crc == CRC_INIT))
        else $error("frame state not restarted after last byte");
    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !o_res.last) |=> ($stable(r_temp) && $stable(r_hum)))
        else $error("held readings changed mid-frame");
    a_hold_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.last && !o_res.ok) |=> ($stable(r_temp) && $stable(r_hum)))
        else $error("held readings changed on CRC mismatch");
`endif

endmodule
